@@ src/ssrs_pkg.sv @@
package ssrs_pkg;

   // Request codes carried in req_type.
   localparam logic [2:0] OP_CREATE        = 3'd0;
   localparam logic [2:0] OP_DESTROY       = 3'd1;
   localparam logic [2:0] OP_CONTAINS      = 3'd2;
   localparam logic [2:0] OP_SET_KIND      = 3'd3;
   localparam logic [2:0] OP_SET_COLOUR    = 3'd4;
   localparam logic [2:0] OP_SET_INTENSITY = 3'd5;
   localparam logic [2:0] OP_READ          = 3'd6;

   // Result status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
   localparam logic [1:0] ST_ALREADY     = 2'd2;
   localparam logic [1:0] ST_FULL        = 2'd3;

   localparam logic [9:0] INVALID_INDEX = 10'h3FF;
   localparam int         INDEX_LIMIT   = 1024;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  entity_index;
      logic [15:0] entity_generation;
      logic [1:0]  light_kind;
      logic [31:0] colour_red;
      logic [31:0] colour_green;
      logic [31:0] colour_blue;
      logic [31:0] intensity_bits;
   } ssrs_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        present;
      logic [1:0]  out_kind;
      logic [31:0] out_red;
      logic [31:0] out_green;
      logic [31:0] out_blue;
      logic [31:0] out_intensity;
      logic [8:0]  live_count;
   } ssrs_rsp_type;

   // One dense slot: owner id plus the light record.
   typedef struct packed {
      logic [15:0] owner_gen;
      logic [9:0]  owner_index;
      logic [1:0]  kind;
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic [31:0] intensity;
   } ssrs_record_type;

   typedef enum logic [1:0] {
      REC_WR_NONE,
      REC_WR_CREATE,
      REC_WR_UPDATE,
      REC_WR_MOVE
   } ssrs_rec_wr_type;

   typedef enum logic [2:0] {
      SP_WR_NONE,
      SP_WR_SWEEP,
      SP_WR_CREATE,
      SP_WR_MOVE,
      SP_WR_UNMAP
   } ssrs_sp_wr_type;

   typedef struct packed {
      logic            req_load;
      logic            sparse_rd;
      logic            rec_rd;
      logic            rec_rd_last;
      ssrs_rec_wr_type rec_wr;
      ssrs_sp_wr_type  sparse_wr;
      logic            count_inc;
      logic            count_dec;
      logic            result_load;
      logic            sweep_step;
   } ssrs_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       here;
      logic       usable;
      logic       full;
      logic       slot_is_last;
      logic       mover_in_range;
      logic       sweep_done;
   } ssrs_stat_type;

endpackage

@@ src/ssrs_ctrl.sv @@
module ssrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ssrs_pkg::ssrs_stat_type stat,
   output ssrs_pkg::ssrs_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import ssrs_pkg::*;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_DENSE,
      S_EVAL,
      S_MOVE,
      S_UNMAP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sparse_wr  = SP_WR_SWEEP;
            cmd.sweep_step = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.req_load  = 1'b1;
               cmd.sparse_rd = 1'b1;
               state_in      = S_DENSE;
            end
         end
         S_DENSE: begin
            cmd.rec_rd = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            cmd.result_load = 1'b1;
            state_in        = S_IDLE;
            rsp_valid_in    = 1'b1;
            unique case (stat.req_type)
               OP_CREATE: begin
                  if (!stat.here && stat.usable && !stat.full) begin
                     cmd.rec_wr    = REC_WR_CREATE;
                     cmd.sparse_wr = SP_WR_CREATE;
                     cmd.count_inc = 1'b1;
                  end
               end
               OP_DESTROY: begin
                  if (stat.here) begin
                     cmd.rec_rd_last = 1'b1;
                     state_in        = S_MOVE;
                     rsp_valid_in    = 1'b0;
                  end
               end
               OP_SET_KIND, OP_SET_COLOUR, OP_SET_INTENSITY: begin
                  if (stat.here) begin
                     cmd.rec_wr = REC_WR_UPDATE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MOVE: begin
            if (!stat.slot_is_last) begin
               cmd.rec_wr = REC_WR_MOVE;
               if (stat.mover_in_range) begin
                  cmd.sparse_wr = SP_WR_MOVE;
               end
            end
            state_in = S_UNMAP;
         end
         S_UNMAP: begin
            cmd.sparse_wr = SP_WR_UNMAP;
            cmd.count_dec = 1'b1;
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/ssrs_datapath.sv @@
module ssrs_datapath #(
   parameter int MAX_ENTITIES = 1024,
   parameter int CAPACITY     = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ssrs_pkg::ssrs_req_type req_payload,
   input  ssrs_pkg::ssrs_cmd_type cmd,
   output ssrs_pkg::ssrs_stat_type stat,
   output ssrs_pkg::ssrs_rsp_type  rsp_payload
);
   import ssrs_pkg::*;

   localparam int SPARSE_DEPTH = (MAX_ENTITIES < INDEX_LIMIT) ? MAX_ENTITIES : INDEX_LIMIT;
   localparam int SPARSE_AW    = (SPARSE_DEPTH > 1) ? $clog2(SPARSE_DEPTH) : 1;
   localparam int DENSE_AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SLOT_W       = $clog2(CAPACITY + 1);

   logic [SLOT_W-1:0] sparse_mem [SPARSE_DEPTH];
   ssrs_record_type   rec_mem [CAPACITY];

   ssrs_req_type      req_ff;
   logic [SLOT_W-1:0] sparse_rd_ff;
   ssrs_record_type   rec_rd_ff;
   logic [SLOT_W-1:0] count_ff;
   logic [SPARSE_AW-1:0] sweep_ff;
   ssrs_rsp_type      result_ff;

   logic [SLOT_W-1:0]    last_count;
   logic [DENSE_AW-1:0]  slot_addr;
   logic [DENSE_AW-1:0]  last_addr;
   logic [DENSE_AW-1:0]  rec_raddr;
   logic [DENSE_AW-1:0]  rec_waddr;
   ssrs_record_type      rec_wdata;
   logic                 rec_we;
   logic [SPARSE_AW-1:0] sp_waddr;
   logic [SLOT_W-1:0]    sp_wdata;
   logic                 sp_we;
   logic                 usable;
   logic                 here;
   ssrs_rsp_type         result_in;

   assign last_count = count_ff - SLOT_W'(1);
   assign slot_addr  = sparse_rd_ff[DENSE_AW-1:0];
   assign last_addr  = last_count[DENSE_AW-1:0];
   assign rec_raddr  = cmd.rec_rd_last ? last_addr : slot_addr;

   assign usable = (req_ff.entity_index != INVALID_INDEX) &&
                   ({22'd0, req_ff.entity_index} < 32'(MAX_ENTITIES));
   assign here   = usable && (sparse_rd_ff < count_ff) &&
                   (rec_rd_ff.owner_index == req_ff.entity_index) &&
                   (rec_rd_ff.owner_gen == req_ff.entity_generation);

   // Dense record write port.
   always_comb begin
      rec_we    = 1'b1;
      rec_waddr = slot_addr;
      rec_wdata = rec_rd_ff;
      unique case (cmd.rec_wr)
         REC_WR_CREATE: begin
            rec_waddr             = count_ff[DENSE_AW-1:0];
            rec_wdata.owner_gen   = req_ff.entity_generation;
            rec_wdata.owner_index = req_ff.entity_index;
            rec_wdata.kind        = req_ff.light_kind;
            rec_wdata.red         = req_ff.colour_red;
            rec_wdata.green       = req_ff.colour_green;
            rec_wdata.blue        = req_ff.colour_blue;
            rec_wdata.intensity   = req_ff.intensity_bits;
         end
         REC_WR_UPDATE: begin
            unique case (req_ff.req_type)
               OP_SET_KIND: rec_wdata.kind = req_ff.light_kind;
               OP_SET_COLOUR: begin
                  rec_wdata.red   = req_ff.colour_red;
                  rec_wdata.green = req_ff.colour_green;
                  rec_wdata.blue  = req_ff.colour_blue;
               end
               OP_SET_INTENSITY: rec_wdata.intensity = req_ff.intensity_bits;
               default: begin
               end
            endcase
         end
         REC_WR_MOVE: begin
         end
         default: rec_we = 1'b0;
      endcase
   end

   // Sparse table write port.
   always_comb begin
      sp_we    = 1'b1;
      sp_waddr = req_ff.entity_index[SPARSE_AW-1:0];
      sp_wdata = SLOT_W'(CAPACITY);
      unique case (cmd.sparse_wr)
         SP_WR_SWEEP:  sp_waddr = sweep_ff;
         SP_WR_CREATE: sp_wdata = count_ff;
         SP_WR_MOVE: begin
            sp_waddr = rec_rd_ff.owner_index[SPARSE_AW-1:0];
            sp_wdata = sparse_rd_ff;
         end
         SP_WR_UNMAP: begin
         end
         default: sp_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sparse_mem[sp_waddr] <= sp_wdata;
      end
      if (cmd.sparse_rd) begin
         sparse_rd_ff <= sparse_mem[req_payload.entity_index[SPARSE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      if (cmd.rec_rd || cmd.rec_rd_last) begin
         rec_rd_ff <= rec_mem[rec_raddr];
      end
   end

   always_comb begin
      result_in         = '0;
      result_in.present = here;
      unique case (req_ff.req_type)
         OP_CREATE: begin
            if (here) begin
               result_in.status = ST_ALREADY;
            end else if (!usable) begin
               result_in.status = ST_NOT_PRESENT;
            end else if (count_ff == SLOT_W'(CAPACITY)) begin
               result_in.status = ST_FULL;
            end else begin
               result_in.status = ST_OK;
            end
         end
         OP_DESTROY, OP_CONTAINS, OP_SET_KIND, OP_SET_COLOUR, OP_SET_INTENSITY: begin
            result_in.status = here ? ST_OK : ST_NOT_PRESENT;
         end
         OP_READ: begin
            result_in.status = here ? ST_OK : ST_NOT_PRESENT;
            if (here) begin
               result_in.out_kind      = rec_rd_ff.kind;
               result_in.out_red       = rec_rd_ff.red;
               result_in.out_green     = rec_rd_ff.green;
               result_in.out_blue      = rec_rd_ff.blue;
               result_in.out_intensity = rec_rd_ff.intensity;
            end
         end
         default: result_in.status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_payload;
      end
      if (cmd.result_load) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         if (cmd.count_inc) begin
            count_ff <= count_ff + SLOT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= last_count;
         end
         if (cmd.sweep_step) begin
            sweep_ff <= sweep_ff + SPARSE_AW'(1);
         end
      end
   end

   always_comb begin
      stat.req_type       = req_ff.req_type;
      stat.here           = here;
      stat.usable         = usable;
      stat.full           = (count_ff == SLOT_W'(CAPACITY));
      stat.slot_is_last   = (sparse_rd_ff == last_count);
      stat.mover_in_range = ({22'd0, rec_rd_ff.owner_index} < 32'(MAX_ENTITIES));
      stat.sweep_done     = (sweep_ff == SPARSE_AW'(SPARSE_DEPTH - 1));
   end

   always_comb begin
      rsp_payload            = result_ff;
      rsp_payload.live_count = 9'(count_ff);
   end

endmodule

@@ src/sparse_set_record_store.sv @@
// Sparse-set record store of light records.
// Requests come in on req_payload and are transferred at a rising clock edge
// where start is high and busy is low. Each request yields exactly one result
// on rsp_payload, shown for one cycle with rsp_valid high; the receiver takes
// every result and cannot stall the block.
// Each request passes through one sparse table read, one dense record read,
// then the decision and writes. A destroy of a present entity also passes
// through S_MOVE and S_UNMAP, since the swap-remove reads the last record and
// then needs up to two sparse table writes on the single write port.
// One request is in flight at a time; busy drops in the cycle the result is
// shown, so the next request can be transferred while that result is out.
// Reset is synchronous and active high. After reset the block sweeps the
// sparse table, writing the empty marker to one entry per cycle across all
// min(MAX_ENTITIES, 1024) entries (1024 by default) with busy high.
// Dense records carry no reset; a record read is only used when its slot is below the live count.
module sparse_set_record_store #(
   parameter int MAX_ENTITIES = 1024,
   parameter int CAPACITY     = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ssrs_pkg::ssrs_req_type req_payload,
   output logic                   rsp_valid,
   output ssrs_pkg::ssrs_rsp_type rsp_payload
);
   import ssrs_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   ssrs_cmd_type  cmd;
   ssrs_stat_type stat;

   // The controller sequences the reset sweep, the lookup, the swap-remove and the result transfer.
   ssrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the sparse table, the dense records and the live count.
   ssrs_datapath #(
      .MAX_ENTITIES (MAX_ENTITIES),
      .CAPACITY     (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule
